// ----- src/dvf_pkg.sv -----
// shared constants and command/status types for the distinct value filter
`default_nettype none
package dvf_pkg;

    localparam int TableDepthDefault = 128;
    localparam int ValueWidth        = 32;
    localparam int SlotWidth         = 7;

    typedef struct packed {
        logic load;       // latch an accepted item and restart the search
        logic search_en;  // step the table scan
        logic finish;     // append if needed and load the result register
    } t_cmd;

    typedef struct packed {
        logic done;       // scan has hit or run past the last entry
        logic out_free;   // result register can take a new result
    } t_sts;

endpackage
`default_nettype wire

// ----- src/dvf_if.sv -----
// handshake channels for items in and results out
`default_nettype none
interface dvf_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dvf_pkg::ValueWidth-1:0]   value;
    logic                                    start_new;

    modport source (output valid, output value, output start_new, input ready);
    modport sink   (input valid, input value, input start_new, output ready);
endinterface

interface dvf_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [dvf_pkg::ValueWidth-1:0]   echo_value;
    logic                                    is_new;
    logic        [dvf_pkg::SlotWidth-1:0]    slot;
    logic                                    overflow;

    modport source (output valid, output echo_value, output is_new, output slot,
                    output overflow, input ready);
    modport sink   (input valid, input echo_value, input is_new, input slot,
                    input overflow, output ready);
endinterface
`default_nettype wire

// ----- src/dvf_ctrl.sv -----
// controller state machine: accept, scan, finish
`default_nettype none
module dvf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire dvf_pkg::t_sts i_sts,
    output dvf_pkg::t_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                o_cmd.search_en = 1'b1;
                if (i_sts.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold here while the previous result is still waiting
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/dvf_dpath.sv -----
// datapath: value table, entry count, scan pointer and result register
`default_nettype none
module dvf_dpath #(
    parameter int TABLE_DEPTH = dvf_pkg::TableDepthDefault
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire dvf_pkg::t_cmd                         i_cmd,
    output dvf_pkg::t_sts                              o_sts,
    input  wire logic signed [dvf_pkg::ValueWidth-1:0] i_value,
    input  wire logic                                  i_start_new,
    input  wire logic                                  i_out_ready,
    output logic                                       o_out_valid,
    output logic signed [dvf_pkg::ValueWidth-1:0]      o_echo_value,
    output logic                                       o_is_new,
    output logic        [dvf_pkg::SlotWidth-1:0]       o_slot,
    output logic                                       o_overflow
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DepthVal = CW'(TABLE_DEPTH);

    logic [dvf_pkg::ValueWidth-1:0] r_mem [TABLE_DEPTH];

    logic [dvf_pkg::ValueWidth-1:0] r_value;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_idx;
    logic [CW-1:0]                  r_pidx;
    logic                           r_pend;
    logic                           r_found;
    logic [CW-1:0]                  r_pos;
    logic [dvf_pkg::ValueWidth-1:0] r_rd_data;
    logic                           r_ovalid;

    logic        w_match;
    logic        w_issue;
    logic        w_room;
    logic [CW-1:0] w_res_pos;
    logic [31:0] w_pos_ext;

    assign w_match = i_cmd.search_en && r_pend && !r_found && (r_rd_data == r_value);
    assign w_issue = i_cmd.search_en && !w_match && !r_found && (r_idx < r_count);
    assign w_room  = (r_count < DepthVal);

    assign o_sts.done     = r_found || (!r_pend && (r_idx >= r_count));
    assign o_sts.out_free = !r_ovalid || i_out_ready;

    // slot of the result: hit position, append position, or zero on overflow
    always_comb begin
        priority if (r_found) begin
            w_res_pos = r_pos;
        end else if (w_room) begin
            w_res_pos = r_count;
        end else begin
            w_res_pos = '0;
        end
    end
    assign w_pos_ext = 32'(w_res_pos);

    // table storage, one read and one write port
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[IW-1:0]];
        end
        if (i_cmd.finish && !r_found && w_room) begin
            r_mem[r_count[IW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_pidx   <= '0;
            r_pend   <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_start_new) begin
                    r_count <= '0;
                end
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (i_cmd.search_en) begin
                r_pend <= w_issue;
                r_pidx <= r_idx;
                if (w_issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (w_match) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish && !r_found && w_room) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.finish) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (w_match) begin
            r_pos <= r_pidx;
        end
        if (i_cmd.finish) begin
            o_echo_value <= r_value;
            o_is_new     <= !r_found;
            o_overflow   <= !r_found && !w_room;
            o_slot       <= w_pos_ext[dvf_pkg::SlotWidth-1:0];
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

// ----- src/distinct_value_filter_core.sv -----
// distinct value filter: linear-search deduplication table, top level
// the scan reads one table entry per cycle and stops at a hit or past the last entry
// a new item is taken only once the previous one has been scanned and finished
// the scan through the table memory sets the item time
// a result waits in the output register while the next item is taken and scanned
// reset empties the table at once (entry count to zero); table contents need no clearing
`default_nettype none
module distinct_value_filter_core #(
    parameter int TABLE_DEPTH = dvf_pkg::TableDepthDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dvf_in_if.sink     i_in,
    dvf_out_if.source  o_out
);

    dvf_pkg::t_cmd w_cmd;
    dvf_pkg::t_sts w_sts;

    dvf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dvf_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_value      (i_in.value),
        .i_start_new  (i_in.start_new),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_echo_value (o_out.echo_value),
        .o_is_new     (o_out.is_new),
        .o_slot       (o_out.slot),
        .o_overflow   (o_out.overflow)
    );

    // one item at a time: no second accept straight after the first
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while previous one still in work");

    // a dropped value is new and reports slot zero
    a_overflow_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (o_out.is_new && (o_out.slot == '0)))
        else $error("overflow result without is_new or with nonzero slot");

    // load and finish never coincide
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load && w_cmd.finish))
        else $error("load and finish commanded together");

endmodule
`default_nettype wire
